### hdl/rcm_pkg.sv
package rcm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 80;

  localparam logic [CFG_INDEX_W-1:0] REG_STICK_CENTER   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SERVO_MAX = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SERVO_MIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MID_SERVO_MAX  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MID_SERVO_MIN  = 3'd5;

  localparam logic [2:0] STEP_NONE   = 3'd0;
  localparam logic [2:0] STEP_ROT_S  = 3'd1;
  localparam logic [2:0] STEP_ROT_D  = 3'd2;
  localparam logic [2:0] STEP_DUTY_X = 3'd3;
  localparam logic [2:0] STEP_DUTY_Y = 3'd4;
  localparam logic [2:0] STEP_FINAL  = 3'd5;

  localparam logic [1:0] BRIDGE_BRAKE = 2'd3;
  localparam logic [1:0] BRIDGE_ONE   = 2'd1;
  localparam logic [1:0] BRIDGE_TWO   = 2'd2;

  localparam logic [26:0] ROT_K     = 27'd46341;
  localparam logic [26:0] RECIP_POS = 27'd1191882;
  localparam logic [26:0] RECIP_NEG = 27'd2145387;
  localparam logic [26:0] RECIP_PWM = 27'd32800032;

  localparam logic [9:0] DUTY_FULL = 10'd1023;

  typedef struct packed {
    logic       load_in;
    logic [2:0] step;
    logic       load_out;
  } cmd_t;

endpackage

### hdl/rcm_ctrl.sv
module rcm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rcm_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROT_S  = 3'd1;
  localparam logic [2:0] S_ROT_D  = 3'd2;
  localparam logic [2:0] S_DUTY_X = 3'd3;
  localparam logic [2:0] S_DUTY_Y = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.step     = rcm_pkg::STEP_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_ROT_S;
        end
      end
      S_ROT_S: begin
        cmd.step   = rcm_pkg::STEP_ROT_S;
        state_next = S_ROT_D;
      end
      S_ROT_D: begin
        cmd.step   = rcm_pkg::STEP_ROT_D;
        state_next = S_DUTY_X;
      end
      S_DUTY_X: begin
        cmd.step   = rcm_pkg::STEP_DUTY_X;
        state_next = S_DUTY_Y;
      end
      S_DUTY_Y: begin
        cmd.step   = rcm_pkg::STEP_DUTY_Y;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.step = rcm_pkg::STEP_FINAL;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_load_reaches_final: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> ##5 (state == S_FINAL))
    else $error("item did not reach the final step on time");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");
`endif

endmodule

### hdl/rcm_dp.sv
module rcm_dp #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rcm_pkg::cmd_t                       cmd,
  input  logic [rcm_pkg::IN_DATA_W-1:0]       in_data,
  output logic [rcm_pkg::OUT_DATA_W-1:0]      out_data,
  input  logic                                cfg_wr_en,
  input  logic [rcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CAPTURE_BITS = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam logic [15:0] WIDTH_MASK = 16'((17'(1) << CAPTURE_BITS) - 17'(1));

  logic [15:0] stick_center;
  logic [7:0]  dead_band;
  logic [12:0] left_servo_max;
  logic [12:0] left_servo_min;
  logic [12:0] mid_servo_max;
  logic [12:0] mid_servo_min;
  logic [12:0] left_servo_pos;
  logic [12:0] mid_servo_pos;

  logic signed [17:0] s_sum;
  logic signed [17:0] s_dif;
  logic [3:0]         keys;
  logic signed [17:0] rx;
  logic signed [17:0] ry;
  logic [9:0]         xd_mag;
  logic               xd_neg;
  logic [9:0]         yd_mag;
  logic               yd_neg;

  logic [1:0]  m1_bridge;
  logic [14:0] m1_pwm;
  logic [1:0]  m2_bridge;
  logic [9:0]  m2_pwm;
  logic [1:0]  m3_bridge;
  logic [9:0]  m3_pwm;
  logic [1:0]  m4_bridge;
  logic [9:0]  m4_pwm;
  logic [12:0] left_servo_duty;
  logic [12:0] mid_servo_duty;

  logic [15:0]        ch1;
  logic [15:0]        ch2;
  logic signed [16:0] x_in;
  logic signed [16:0] y_in;

  logic signed [26:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [45:0] mul_p;
  logic signed [45:0] rot_adj;
  logic signed [17:0] rot_q;

  logic signed [17:0] ax;
  logic signed [17:0] ax_negated;
  logic [9:0]         ax_mag;
  logic signed [17:0] db_s;
  logic               ax_pos_hi;
  logic               ax_neg_hi;
  logic               ax_in_db;
  logic [9:0]         duty_mag;

  logic       spin_right;
  logic       spin_left;
  logic [9:0] d1_mag, d2_mag, d3_mag, d4_mag;
  logic       d1_neg, d2_neg, d3_neg, d4_neg;

  logic k1, k2, k3, k4;

  function automatic logic [1:0] bridge_code(input logic neg, input logic [9:0] mag,
                                             input logic [1:0] pos_code,
                                             input logic [1:0] neg_code);
    logic [1:0] code;
    if (mag == 10'd0) begin
      code = rcm_pkg::BRIDGE_BRAKE;
    end else if (neg) begin
      code = neg_code;
    end else begin
      code = pos_code;
    end
    return code;
  endfunction

  assign ch1  = in_data[15:0] & WIDTH_MASK;
  assign ch2  = in_data[31:16] & WIDTH_MASK;
  assign x_in = $signed({1'b0, ch2}) - $signed({1'b0, stick_center});
  assign y_in = $signed({1'b0, ch1}) - $signed({1'b0, stick_center});

  assign k1 = keys[0];
  assign k2 = keys[1];
  assign k3 = keys[2];
  assign k4 = keys[3];

  assign ax         = (cmd.step == rcm_pkg::STEP_DUTY_Y) ? ry : rx;
  assign ax_negated = -ax;
  assign ax_mag     = ax[17] ? ax_negated[9:0] : ax[9:0];
  assign db_s       = $signed({10'b0, dead_band});
  assign ax_pos_hi  = ax > 18'sd900;
  assign ax_neg_hi  = ax < -18'sd500;
  assign ax_in_db   = (ax > -db_s) && (ax < db_s);

  always_comb begin
    mul_a = rcm_pkg::ROT_K;
    mul_b = 19'(s_sum);
    unique case (cmd.step)
      rcm_pkg::STEP_ROT_S: begin
        mul_a = rcm_pkg::ROT_K;
        mul_b = 19'(s_sum);
      end
      rcm_pkg::STEP_ROT_D: begin
        mul_a = rcm_pkg::ROT_K;
        mul_b = 19'(s_dif);
      end
      rcm_pkg::STEP_DUTY_X, rcm_pkg::STEP_DUTY_Y: begin
        mul_a = ax[17] ? rcm_pkg::RECIP_NEG : rcm_pkg::RECIP_POS;
        mul_b = $signed({9'b0, ax_mag});
      end
      rcm_pkg::STEP_FINAL: begin
        mul_a = rcm_pkg::RECIP_PWM;
        mul_b = $signed({9'b0, d1_mag});
      end
      default: begin
        mul_a = rcm_pkg::ROT_K;
        mul_b = 19'(s_sum);
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rot_adj = mul_p + (mul_p[45] ? 46'sd65535 : 46'sd0);
  assign rot_q   = rot_adj[33:16];

  always_comb begin
    if (ax_pos_hi || ax_neg_hi) begin
      duty_mag = rcm_pkg::DUTY_FULL;
    end else if (ax_in_db) begin
      duty_mag = 10'd0;
    end else begin
      duty_mag = mul_p[29:20];
    end
  end

  assign spin_right = !k4 && !k3;
  assign spin_left  = !spin_right && !k2 && !k1;

  always_comb begin
    if (spin_right) begin
      d1_mag = rcm_pkg::DUTY_FULL;  d1_neg = 1'b1;
      d2_mag = rcm_pkg::DUTY_FULL;  d2_neg = 1'b0;
      d3_mag = rcm_pkg::DUTY_FULL;  d3_neg = 1'b1;
      d4_mag = rcm_pkg::DUTY_FULL;  d4_neg = 1'b0;
    end else if (spin_left) begin
      d1_mag = rcm_pkg::DUTY_FULL;  d1_neg = 1'b0;
      d2_mag = rcm_pkg::DUTY_FULL;  d2_neg = 1'b1;
      d3_mag = rcm_pkg::DUTY_FULL;  d3_neg = 1'b0;
      d4_mag = rcm_pkg::DUTY_FULL;  d4_neg = 1'b1;
    end else begin
      d1_mag = yd_mag;  d1_neg = yd_neg;
      d2_mag = xd_mag;  d2_neg = xd_neg;
      d3_mag = xd_mag;  d3_neg = xd_neg;
      d4_mag = yd_mag;  d4_neg = yd_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_center   <= 16'd1550;
      dead_band      <= 8'd20;
      left_servo_max <= 13'd4600;
      left_servo_min <= 13'd2300;
      mid_servo_max  <= 13'd4000;
      mid_servo_min  <= 13'd2500;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcm_pkg::REG_STICK_CENTER:   stick_center   <= cfg_wdata;
        rcm_pkg::REG_DEAD_BAND:      dead_band      <= cfg_wdata[7:0];
        rcm_pkg::REG_LEFT_SERVO_MAX: left_servo_max <= cfg_wdata[12:0];
        rcm_pkg::REG_LEFT_SERVO_MIN: left_servo_min <= cfg_wdata[12:0];
        rcm_pkg::REG_MID_SERVO_MAX:  mid_servo_max  <= cfg_wdata[12:0];
        rcm_pkg::REG_MID_SERVO_MIN:  mid_servo_min  <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_servo_pos <= 13'd3000;
      mid_servo_pos  <= 13'd3000;
    end else if (cmd.load_out) begin
      if (k2 && !k1 && (left_servo_pos < left_servo_max)) begin
        left_servo_pos <= left_servo_pos + 13'd1;
      end else if (k1 && !k2 && (left_servo_pos > left_servo_min)) begin
        left_servo_pos <= left_servo_pos - 13'd1;
      end
      if (k4 && !k3 && (mid_servo_pos < mid_servo_max)) begin
        mid_servo_pos <= mid_servo_pos + 13'd1;
      end else if (k3 && !k4 && (mid_servo_pos > mid_servo_min)) begin
        mid_servo_pos <= mid_servo_pos - 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_sum <= 18'(x_in) + 18'(y_in);
      s_dif <= 18'(y_in) - 18'(x_in);
      keys  <= in_data[35:32];
    end
    if (cmd.step == rcm_pkg::STEP_ROT_S) begin
      rx <= rot_q;
    end
    if (cmd.step == rcm_pkg::STEP_ROT_D) begin
      ry <= rot_q;
    end
    if (cmd.step == rcm_pkg::STEP_DUTY_X) begin
      xd_mag <= duty_mag;
      xd_neg <= ax[17];
    end
    if (cmd.step == rcm_pkg::STEP_DUTY_Y) begin
      yd_mag <= duty_mag;
      yd_neg <= ax[17];
    end
    if (cmd.load_out) begin
      m1_bridge       <= bridge_code(d1_neg, d1_mag, rcm_pkg::BRIDGE_TWO, rcm_pkg::BRIDGE_ONE);
      m1_pwm          <= mul_p[34:20];
      m2_bridge       <= bridge_code(d2_neg, d2_mag, rcm_pkg::BRIDGE_ONE, rcm_pkg::BRIDGE_TWO);
      m2_pwm          <= d2_mag;
      m3_bridge       <= bridge_code(d3_neg, d3_mag, rcm_pkg::BRIDGE_TWO, rcm_pkg::BRIDGE_ONE);
      m3_pwm          <= d3_mag;
      m4_bridge       <= bridge_code(d4_neg, d4_mag, rcm_pkg::BRIDGE_ONE, rcm_pkg::BRIDGE_TWO);
      m4_pwm          <= d4_mag;
      left_servo_duty <= left_servo_pos;
      mid_servo_duty  <= mid_servo_pos;
    end
  end

  assign out_data = {1'b0, mid_servo_duty, left_servo_duty, m4_pwm, m4_bridge, m3_pwm,
                     m3_bridge, m2_pwm, m2_bridge, m1_pwm, m1_bridge};

`ifndef SYNTH
  a_servo_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd.load_out |=> $stable(left_servo_pos) && $stable(mid_servo_pos))
    else $error("servo position moved outside a result load");

  a_brake_no_pwm: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) && (m1_bridge == rcm_pkg::BRIDGE_BRAKE) |-> (m1_pwm == 15'd0))
    else $error("motor 1 braked with nonzero pwm");
`endif

endmodule

### hdl/rc_stick_to_four_motor_mixer_top.sv
// An accepted beat passes ROT_S, ROT_D, DUTY_X, DUTY_Y and FINAL, and FINAL waits while
// the output register still holds a result. A new beat is taken only while idle; one shared
// multiplier forms five products per item. A finished result waits in the output register
// while the next beat is taken in. Reset is synchronous: it clears control, restores
// register defaults and sets both servo positions to 3000.
module rc_stick_to_four_motor_mixer_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // ch1_width[15:0], ch2_width[31:16], key1_level..key4_level[35:32], zero fill.
  input  logic [rcm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // m1_bridge, m1_pwm, m2_bridge, m2_pwm, m3_bridge, m3_pwm, m4_bridge, m4_pwm,
  // left_servo_duty, mid_servo_duty from the lowest bit up, zero fill.
  output logic [rcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_wr_en,
  input  logic [rcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  rcm_pkg::cmd_t cmd;

  rcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  rcm_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
